### design/kdce_pkg.sv
// ----------------------------------------------------------------------------
// kdce_pkg
// Shared types and constants for the key debounce and click event block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kdce_pkg;

    // number of keys that have a level, polarity and enable bit
    localparam int HW_KEYS     = 4;
    localparam int KEY_IDX_W   = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE    = 3'd5;

    // reset values of the configuration registers
    localparam logic [7:0] RST_SCAN_INTERVAL = 8'd10;
    localparam logic [7:0] RST_LONG_START    = 8'd20;
    localparam logic [7:0] RST_SHORT         = 8'd30;
    localparam logic [7:0] RST_LONG          = 8'd100;
    localparam logic [3:0] RST_PRESS_LEVEL   = 4'h0;
    localparam logic [3:0] RST_KEY_ENABLE    = 4'hF;

    // reported event codes
    localparam logic [2:0] EVT_NONE       = 3'd0;
    localparam logic [2:0] EVT_PRESS      = 3'd1;
    localparam logic [2:0] EVT_RELEASE    = 3'd2;
    localparam logic [2:0] EVT_LONG_START = 3'd3;
    localparam logic [2:0] EVT_LONG_HOLD  = 3'd4;
    localparam logic [2:0] EVT_CLICK      = 3'd5;
    localparam logic [2:0] EVT_REPEAT     = 3'd6;

    // settings the per-key engine reads during a scan
    typedef struct packed {
        logic [7:0] long_start_ticks;
        logic [7:0] click_gap;
        logic [7:0] hold_period;
        logic [3:0] press_level_mask;
        logic [3:0] key_enable_mask;
    } key_cfg_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

### design/kdce_queue.sv
// ----------------------------------------------------------------------------
// kdce_queue
// Small FIFO that holds scan requests between the tick front end and the
// per-key engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdce_queue #(
    parameter int W     = 4,
    parameter int DEPTH = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [W-1:0]          push_data,
    input  wire logic                  pop,
    output logic      [W-1:0]          pop_data,
    output kdce_pkg::queue_stat_t      stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/kdce_front.sv
// ----------------------------------------------------------------------------
// kdce_front
// Tick front end: accumulates elapsed milliseconds and queues a scan request
// with the sampled key levels whenever the scan interval is reached.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdce_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            elapsed_ms,
    input  wire logic [3:0]            key_levels,
    input  wire logic [7:0]            scan_interval_ms,
    input  wire kdce_pkg::queue_stat_t q_stat,
    output logic                       push,
    output logic      [3:0]            push_data
);

    logic [7:0] acc_reg, acc_next;
    logic [8:0] sum;
    logic [7:0] sum_sat;
    logic       accept;
    logic       scan_hit;

    assign in_stall  = q_stat.full;
    assign accept    = in_valid && !in_stall;
    assign sum       = {1'b0, acc_reg} + {1'b0, elapsed_ms};
    assign sum_sat   = sum[8] ? 8'hFF : sum[7:0];
    assign scan_hit  = (sum_sat >= scan_interval_ms);
    assign push      = accept && scan_hit;
    assign push_data = key_levels;

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = scan_hit ? 8'd0 : sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'd0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

### design/kdce_back.sv
// ----------------------------------------------------------------------------
// kdce_back
// Per-key engine: pops a scan request and steps through the keys one per
// cycle unless stalled, running debounce/event machines, registering results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdce_back #(
    parameter int NUM_KEYS = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kdce_pkg::key_cfg_t    cfg,
    input  wire kdce_pkg::queue_stat_t q_stat,
    input  wire logic [3:0]            q_data,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 key_index,
    output logic [2:0]                 event_code,
    output logic [7:0]                 repeat_count,
    output logic                       last
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int IW = kdce_pkg::KEY_IDX_W;

    typedef enum logic [1:0] {
        DB_UP, DB_DOWN_SHAKE, DB_DOWN, DB_UP_SHAKE
    } db_state_t;

    typedef enum logic [2:0] {
        EV_INIT, EV_PRESS, EV_CLICK, EV_REPEAT_DOWN, EV_LONG
    } ev_state_t;

    typedef enum logic {
        SEQ_IDLE, SEQ_SCAN
    } seq_state_t;

    seq_state_t     seq_reg, seq_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [3:0]     levels_reg, levels_next;

    db_state_t      db_reg     [NUM_KEYS];
    logic           sp_reg     [NUM_KEYS];
    ev_state_t      ev_reg     [NUM_KEYS];
    logic [7:0]     cnt_reg    [NUM_KEYS];
    logic [7:0]     clicks_reg [NUM_KEYS];

    logic           out_valid_reg, out_valid_next;
    logic [IW-1:0]  key_index_reg, key_index_next;
    logic [2:0]     event_code_reg, event_code_next;
    logic [7:0]     repeat_count_reg, repeat_count_next;
    logic           last_reg, last_next;

    logic [NUM_KEYS-1:0] en_vec, lvl_vec, pol_vec, en_above;
    logic           key_en, level_pressed, slot_free, load, step, last_key;

    db_state_t      db_cur, db_new;
    logic           sp_new;
    ev_state_t      ev_cur, ev_new;
    logic [7:0]     cnt_cur, cnt_new, cnt_inc;
    logic [7:0]     clicks_cur, clicks_new, clicks_sat;
    logic [2:0]     evt;
    logic [7:0]     evt_count;

    // keys beyond the hardware mask width stay disabled
    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (i < kdce_pkg::HW_KEYS)
            begin
                en_vec[i]  = cfg.key_enable_mask[i];
                lvl_vec[i] = levels_reg[i];
                pol_vec[i] = cfg.press_level_mask[i];
            end
            else
            begin
                en_vec[i]  = 1'b0;
                lvl_vec[i] = 1'b0;
                pol_vec[i] = 1'b0;
            end
        end
    end

    assign key_en        = en_vec[k_reg];
    assign level_pressed = (lvl_vec[k_reg] == pol_vec[k_reg]);
    assign en_above      = (en_vec >> k_reg) >> 1;
    assign last_key      = (k_reg == KW'(NUM_KEYS - 1));
    assign slot_free     = !out_valid_reg || !out_stall;
    assign load          = (seq_reg == SEQ_SCAN) && key_en && slot_free;
    assign step          = (seq_reg == SEQ_SCAN) && (!key_en || slot_free);
    assign pop           = (seq_reg == SEQ_IDLE) && !q_stat.empty;

    assign db_cur     = db_reg[k_reg];
    assign ev_cur     = ev_reg[k_reg];
    assign cnt_cur    = cnt_reg[k_reg];
    assign clicks_cur = clicks_reg[k_reg];
    assign cnt_inc    = cnt_cur + 8'd1;
    assign clicks_sat = (clicks_cur == 8'hFF) ? clicks_cur : clicks_cur + 8'd1;

    // debounce machine of the selected key
    always_comb
    begin
        db_new = db_cur;
        sp_new = sp_reg[k_reg];
        unique case (db_cur)
            DB_UP:
            begin
                if (level_pressed)
                begin
                    db_new = DB_DOWN_SHAKE;
                end
                else
                begin
                    sp_new = 1'b0;
                end
            end
            DB_DOWN:
            begin
                if (level_pressed)
                begin
                    sp_new = 1'b1;
                end
                else
                begin
                    db_new = DB_UP_SHAKE;
                end
            end
            default:
            begin
                db_new = level_pressed ? DB_DOWN : DB_UP;
            end
        endcase
    end

    // event machine, compares use the counter value before the increment
    always_comb
    begin
        ev_new     = ev_cur;
        cnt_new    = cnt_cur;
        clicks_new = clicks_cur;
        evt        = kdce_pkg::EVT_NONE;
        evt_count  = 8'd0;
        unique case (ev_cur)
            EV_INIT:
            begin
                if (sp_new)
                begin
                    ev_new = EV_PRESS;
                    evt    = kdce_pkg::EVT_PRESS;
                end
            end
            EV_PRESS:
            begin
                if (sp_new)
                begin
                    cnt_new = cnt_inc;
                    if (cnt_cur > cfg.long_start_ticks)
                    begin
                        cnt_new = 8'd0;
                        ev_new  = EV_LONG;
                        evt     = kdce_pkg::EVT_LONG_START;
                    end
                end
                else
                begin
                    clicks_new = clicks_sat;
                    ev_new     = EV_CLICK;
                    evt        = kdce_pkg::EVT_RELEASE;
                end
            end
            EV_CLICK:
            begin
                if (sp_new)
                begin
                    cnt_new = 8'd0;
                    ev_new  = EV_REPEAT_DOWN;
                end
                else
                begin
                    cnt_new = cnt_inc;
                    if (cnt_cur >= cfg.click_gap)
                    begin
                        cnt_new    = 8'd0;
                        ev_new     = EV_INIT;
                        clicks_new = 8'd0;
                        if (clicks_cur > 8'd1)
                        begin
                            evt       = kdce_pkg::EVT_REPEAT;
                            evt_count = clicks_cur;
                        end
                        else
                        begin
                            evt = kdce_pkg::EVT_CLICK;
                        end
                    end
                end
            end
            EV_REPEAT_DOWN:
            begin
                if (sp_new)
                begin
                    cnt_new = cnt_inc;
                    if (cnt_cur >= {1'b0, cfg.hold_period[7:1]})
                    begin
                        evt        = kdce_pkg::EVT_REPEAT;
                        evt_count  = clicks_sat;
                        clicks_new = 8'd0;
                        ev_new     = EV_LONG;
                        cnt_new    = 8'd0;
                    end
                end
                else
                begin
                    ev_new     = EV_CLICK;
                    clicks_new = clicks_sat;
                end
            end
            EV_LONG:
            begin
                if (sp_new)
                begin
                    cnt_new = cnt_inc;
                    if (cnt_cur >= cfg.hold_period)
                    begin
                        cnt_new = 8'd0;
                        evt     = kdce_pkg::EVT_LONG_HOLD;
                    end
                end
                else
                begin
                    ev_new  = EV_INIT;
                    cnt_new = 8'd0;
                    evt     = kdce_pkg::EVT_RELEASE;
                end
            end
            default:
            begin
                ev_new = EV_INIT;
            end
        endcase
    end

    always_comb
    begin
        seq_next          = seq_reg;
        k_next            = k_reg;
        levels_next       = levels_reg;
        out_valid_next    = out_valid_reg && out_stall;
        key_index_next    = key_index_reg;
        event_code_next   = event_code_reg;
        repeat_count_next = repeat_count_reg;
        last_next         = last_reg;
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (pop)
                begin
                    levels_next = q_data;
                    k_next      = '0;
                    seq_next    = SEQ_SCAN;
                end
            end
            SEQ_SCAN:
            begin
                if (load)
                begin
                    out_valid_next    = 1'b1;
                    key_index_next    = IW'(k_reg);
                    event_code_next   = evt;
                    repeat_count_next = evt_count;
                    last_next         = !(|en_above);
                end
                if (step)
                begin
                    if (last_key)
                    begin
                        seq_next = SEQ_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= SEQ_IDLE;
            k_reg            <= '0;
            levels_reg       <= '0;
            out_valid_reg    <= 1'b0;
            key_index_reg    <= '0;
            event_code_reg   <= kdce_pkg::EVT_NONE;
            repeat_count_reg <= 8'd0;
            last_reg         <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                db_reg[i]     <= DB_UP;
                sp_reg[i]     <= 1'b0;
                ev_reg[i]     <= EV_INIT;
                cnt_reg[i]    <= 8'd0;
                clicks_reg[i] <= 8'd0;
            end
        end
        else
        begin
            seq_reg          <= seq_next;
            k_reg            <= k_next;
            levels_reg       <= levels_next;
            out_valid_reg    <= out_valid_next;
            key_index_reg    <= key_index_next;
            event_code_reg   <= event_code_next;
            repeat_count_reg <= repeat_count_next;
            last_reg         <= last_next;
            if (load)
            begin
                db_reg[k_reg]     <= db_new;
                sp_reg[k_reg]     <= sp_new;
                ev_reg[k_reg]     <= ev_new;
                cnt_reg[k_reg]    <= cnt_new;
                clicks_reg[k_reg] <= clicks_new;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_index    = key_index_reg;
    assign event_code   = event_code_reg;
    assign repeat_count = repeat_count_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### design/key_debounce_click_event_fsm_core.sv
// ----------------------------------------------------------------------------
// key_debounce_click_event_fsm_core
// Debounce and click/long-press event detection for a bank of push keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per timer tick carrying
//   elapsed_ms and the sampled key_levels. Ticks that do not reach the scan
//   interval are absorbed into the accumulator and give no result.
//   Output channel (out_valid / out_stall): one result per enabled key for
//   each scan, in ascending key order, with last set on the final one.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   only while no scan is in flight. Unknown indexes are dropped.
//   Flow: an accepted scanning tick passes through the request queue, the
//   engine's level register and the output register before its first
//   result; disabled keys are stepped over without a result. The engine
//   pops a new request only after it has stepped through every key of the
//   current scan; a two-entry request queue lets ticks keep arriving while
//   the engine works.
//   Stall: a stalled result holds in the output register and the engine
//   waits on it before loading another; when the queue fills, in_stall rises.
//   Reset: clears the accumulator, all key machines and the queue, and loads
//   the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_click_event_fsm_core #(
    parameter int NUM_KEYS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  elapsed_ms,
    input  wire logic [3:0]  key_levels,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       key_index,
    output logic [2:0]       event_code,
    output logic [7:0]       repeat_count,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0]            scan_interval_reg;
    kdce_pkg::key_cfg_t    cfg_reg;
    kdce_pkg::queue_stat_t q_stat;
    logic                  push, pop;
    logic [3:0]            push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_interval_reg        <= kdce_pkg::RST_SCAN_INTERVAL;
            cfg_reg.long_start_ticks <= kdce_pkg::RST_LONG_START;
            cfg_reg.click_gap        <= kdce_pkg::RST_SHORT;
            cfg_reg.hold_period      <= kdce_pkg::RST_LONG;
            cfg_reg.press_level_mask <= kdce_pkg::RST_PRESS_LEVEL;
            cfg_reg.key_enable_mask  <= kdce_pkg::RST_KEY_ENABLE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kdce_pkg::CFG_SCAN_INTERVAL: scan_interval_reg        <= cfg_data;
                kdce_pkg::CFG_LONG_START:    cfg_reg.long_start_ticks <= cfg_data;
                kdce_pkg::CFG_SHORT:         cfg_reg.click_gap        <= cfg_data;
                kdce_pkg::CFG_LONG:          cfg_reg.hold_period      <= cfg_data;
                kdce_pkg::CFG_PRESS_LEVEL:   cfg_reg.press_level_mask <= cfg_data[3:0];
                kdce_pkg::CFG_KEY_ENABLE:    cfg_reg.key_enable_mask  <= cfg_data[3:0];
                default:                     ;
            endcase
        end
    end

    kdce_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .elapsed_ms       (elapsed_ms),
        .key_levels       (key_levels),
        .scan_interval_ms (scan_interval_reg),
        .q_stat           (q_stat),
        .push             (push),
        .push_data        (push_data)
    );

    kdce_queue #(
        .W     (4),
        .DEPTH (kdce_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    kdce_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .q_data       (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_index    (key_index),
        .event_code   (event_code),
        .repeat_count (repeat_count),
        .last         (last)
    );

endmodule

`default_nettype wire

### design/kdce_checker.sv
// ----------------------------------------------------------------------------
// kdce_checker
// Port-level checks on the result channel of the key event block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdce_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] key_index,
    input wire logic [2:0] event_code,
    input wire logic [7:0] repeat_count,
    input wire logic       last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(key_index)
            && $stable(event_code) && $stable(repeat_count) && $stable(last))
        else $error("stalled result changed");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code != kdce_pkg::EVT_REPEAT |-> repeat_count == 8'd0)
        else $error("nonzero count on a non-repeat event");

    // a repeat always covers at least two clicks
    a_repeat_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == kdce_pkg::EVT_REPEAT |-> repeat_count >= 8'd2)
        else $error("repeat event with fewer than two clicks");

    // results of one scan come in ascending key order
    a_key_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last ##1 out_valid |-> key_index > $past(key_index))
        else $error("key order broken within a scan");

endmodule

bind key_debounce_click_event_fsm_core kdce_checker u_kdce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .key_index    (key_index),
    .event_code   (event_code),
    .repeat_count (repeat_count),
    .last         (last)
);

`default_nettype wire
